// ----- rtl/core/windowed_peak_meter_core_defines.svh -----
// ----------------------------------------------------------------------------
// windowed_peak_meter_core_defines
// Assertion macros shared by the peak meter RTL. Expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PEAK_METER_CORE_DEFINES_SVH
`define WINDOWED_PEAK_METER_CORE_DEFINES_SVH

// same-cycle implication
`define WPM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpm assertion failed");

// next-cycle implication
`define WPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpm assertion failed");

`endif

// ----- rtl/core/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_pkg
// Types and constants for the windowed peak meter.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int CHAN_BITS      = 3;
    localparam int WINDOW_BITS    = 7;
    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_MAX_BLOCKS = 64;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd64;

    typedef struct packed {
        logic [CHAN_BITS-1:0]          channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_end;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0]   out_channel;
        logic [SAMPLE_BITS-1:0] peak_level;
    } out_item_t;

endpackage

// ----- rtl/core/wpm_ram.sv -----
// ----------------------------------------------------------------------------
// wpm_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/windowed_peak_meter_core.sv -----
// ----------------------------------------------------------------------------
// windowed_peak_meter_core
// Per-channel block peak meter with a sliding window of stored block peaks.
// ----------------------------------------------------------------------------
// Plain sample: updates the channel's block peak, no result.
// Block end: writes the ring, reads the W stored peaks of the window, drains
// the last read, then loads the output register once free (W = effective window).
// Output register lets the next transaction enter while a result waits.
// After reset a clearing pass writes zero to all CHANNELS_P2 * 2^SLOT_W ring
// entries, one per cycle (512 at defaults); in_ready stays low until done.
`include "windowed_peak_meter_core_defines.svh"

module windowed_peak_meter_core #(
    parameter int CHANNELS   = wpm_pkg::DEF_CHANNELS,
    parameter int MAX_BLOCKS = wpm_pkg::DEF_MAX_BLOCKS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  wpm_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output wpm_pkg::out_item_t               out_data,
    input  logic                             cfg_wr_en,
    input  logic [wpm_pkg::WINDOW_BITS-1:0]  cfg_wr_data
);

    localparam int PEAK_W    = wpm_pkg::SAMPLE_BITS;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int WIN_W     = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W    = CH_W + SLOT_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int CMP_W     = (WIN_W > wpm_pkg::WINDOW_BITS) ? WIN_W : wpm_pkg::WINDOW_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [wpm_pkg::WINDOW_BITS-1:0] window_reg;
    logic [PEAK_W-1:0]               block_peak_reg [CHANNELS];
    logic [SLOT_W-1:0]               ring_index_reg [CHANNELS];
    logic [1:0]                      state_reg;
    logic [CH_W-1:0]                 ch_reg;
    logic [wpm_pkg::CHAN_BITS-1:0]   chan_reg;
    logic [WIN_W-1:0]                win_reg;
    logic [SLOT_W-1:0]               k_reg;
    logic [PEAK_W-1:0]               best_reg;
    logic                            rd_pend_reg;
    logic                            clr_active_reg;
    logic [ADDR_W-1:0]               clr_addr_reg;
    logic                            out_valid_reg;
    wpm_pkg::out_item_t              out_data_reg;

    logic              accept;
    logic              ch_ok;
    logic              accept_end;
    logic [CH_W-1:0]   ch_idx;
    logic [PEAK_W-1:0] mag;
    logic [PEAK_W-1:0] new_peak;
    logic [CMP_W-1:0]  wb_ext;
    logic [WIN_W-1:0]  win_eff;
    logic [WIN_W-1:0]  cur_ext;
    logic [WIN_W-1:0]  wslot;
    logic [WIN_W-1:0]  slot_inc;
    logic [WIN_W-1:0]  nslot;
    logic              out_free;
    logic              scan_done;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [PEAK_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PEAK_W-1:0] ram_rdata;

    assign in_ready   = (state_reg == ST_IDLE) && !clr_active_reg;
    assign accept     = in_valid && in_ready;
    assign ch_ok      = 32'(in_data.channel) < 32'(CHANNELS);
    assign accept_end = accept && ch_ok && in_data.block_end;
    assign ch_idx     = CH_W'(in_data.channel);
    assign out_free   = !out_valid_reg || out_ready;
    assign scan_done  = WIN_W'(k_reg) == WIN_W'(win_reg - 1'b1);

    // two's complement magnitude; most negative maps onto the sign bit
    assign mag = in_data.sample[PEAK_W-1] ? PEAK_W'(~in_data.sample + 1'b1)
                                          : PEAK_W'(in_data.sample);

    assign new_peak = (mag > block_peak_reg[ch_idx]) ? mag : block_peak_reg[ch_idx];

    always_comb
    begin
        wb_ext = CMP_W'(window_reg);
        if (wb_ext == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (wb_ext > CMP_W'(MAX_BLOCKS))
        begin
            win_eff = WIN_W'(MAX_BLOCKS);
        end
        else
        begin
            win_eff = WIN_W'(wb_ext);
        end
    end

    always_comb
    begin
        cur_ext  = WIN_W'(ring_index_reg[ch_idx]);
        wslot    = (cur_ext >= win_eff) ? '0 : cur_ext;
        slot_inc = WIN_W'(wslot + 1'b1);
        nslot    = (slot_inc >= win_eff) ? '0 : slot_inc;
    end

    assign ram_we    = clr_active_reg || accept_end;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : {ch_idx, SLOT_W'(wslot)};
    assign ram_wdata = clr_active_reg ? '0 : new_peak;
    assign ram_re    = (state_reg == ST_SCAN);
    assign ram_raddr = {ch_reg, k_reg};

    wpm_ram #(
        .WIDTH (PEAK_W),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= wpm_pkg::WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                block_peak_reg[i] <= '0;
                ring_index_reg[i] <= '0;
            end
        end
        else if (accept && ch_ok)
        begin
            if (in_data.block_end)
            begin
                block_peak_reg[ch_idx] <= '0;
                ring_index_reg[ch_idx] <= SLOT_W'(nslot);
            end
            else
            begin
                block_peak_reg[ch_idx] <= new_peak;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= ADDR_W'(clr_addr_reg + 1'b1);
            if (clr_addr_reg == ADDR_W'(RAM_DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == ST_SCAN);
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_end)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        state_reg <= ST_LAST;
                    end
                end
                ST_LAST:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_end)
        begin
            ch_reg   <= ch_idx;
            chan_reg <= in_data.channel;
            win_reg  <= win_eff;
            k_reg    <= '0;
            best_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_SCAN)
            begin
                k_reg <= SLOT_W'(k_reg + 1'b1);
            end
            if (rd_pend_reg && (ram_rdata > best_reg))
            begin
                best_reg <= ram_rdata;
            end
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_data_reg.out_channel <= chan_reg;
            out_data_reg.peak_level  <= best_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `WPM_ASSERT_IMPL(a_scan_in_window, state_reg == ST_SCAN, WIN_W'(k_reg) < win_reg)
    `WPM_ASSERT_NEXT(a_end_starts_scan, accept_end, state_reg == ST_SCAN)
    `WPM_ASSERT_NEXT(a_emit_loads_out, (state_reg == ST_EMIT) && out_free, out_valid_reg)
    `WPM_ASSERT_IMPL(a_last_has_data, state_reg == ST_LAST, rd_pend_reg)

endmodule
